// ----- src/direction_weighted_reprojection_residual_defines.svh -----
// Assertion macros shared by the reprojection residual RTL.
`ifndef DIRECTION_WEIGHTED_REPROJECTION_RESIDUAL_DEFINES_SVH
`define DIRECTION_WEIGHTED_REPROJECTION_RESIDUAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DWRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DWRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dwrr_pkg.sv -----
// Package with types, constants and fixed-point helpers for the reprojection residual.
`default_nettype none
package dwrr_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int DIV_STEPS      = 31;

    localparam logic signed [65:0] ONE30_W = 66'sd1 <<< 30;
    localparam logic signed [65:0] ONE28_W = 66'sd1 <<< 28;
    localparam logic signed [31:0] ONE30_Q = 32'sh4000_0000;
    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

    typedef enum logic {
        OPC_POSE  = 1'b0,
        OPC_POINT = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        REG_FOCAL_X  = 3'd0,
        REG_FOCAL_Y  = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_RAD_K1   = 3'd4,
        REG_RAD_K2   = 3'd5,
        REG_TAN_P1   = 3'd6,
        REG_TAN_P2   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0]        focal_x;
        logic [31:0]        focal_y;
        logic [31:0]        center_x;
        logic [31:0]        center_y;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_cfg;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] e;
        logic signed [31:0] f;
        logic signed [31:0] g;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [31:0] obs_u;
        logic signed [31:0] obs_v;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
    } t_cam_item;

    typedef struct packed {
        logic signed [31:0] obs_u;
        logic signed [31:0] obs_v;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic               behind;
    } t_side;

    typedef struct packed {
        logic signed [31:0] xn;
        logic signed [31:0] yn;
        t_side              side;
    } t_norm_item;

    typedef struct packed {
        logic signed [31:0] ud;
        logic signed [31:0] vd;
        t_side              side;
    } t_proj_item;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > S32_MAX) begin
            res = 32'sh7fff_ffff;
        end else if (v < S32_MIN) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Product brought back by an arithmetic shift (floor), then clamped to 32 bits.
    function automatic logic signed [31:0] mulq(input logic signed [32:0] a,
                                                input logic signed [31:0] b,
                                                input int unsigned s);
        logic signed [64:0] p;
        p = a * b;
        return sat32(66'(p >>> s));
    endfunction

endpackage
`default_nettype wire

// ----- src/dwrr_xform.sv -----
// Pose loading and rigid transform of points into camera coordinates (three stages).
`default_nettype none
module dwrr_xform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  dwrr_pkg::t_in_item  i_item,
    output logic                o_valid,
    output dwrr_pkg::t_cam_item o_item
);
    import dwrr_pkg::*;

    logic               r_s1_v;
    t_in_item           r_s1_item;
    logic signed [31:0] r_s1_xx, r_s1_yy, r_s1_zz, r_s1_xy, r_s1_xz;
    logic signed [31:0] r_s1_yz, r_s1_xw, r_s1_yw, r_s1_zw;

    logic signed [31:0] r_rot [9];
    logic signed [31:0] r_trans [3];

    logic               r_s2_v;
    logic signed [31:0] r_s2_prod [9];
    logic signed [31:0] r_s2_t [3];
    logic signed [31:0] r_s2_obs_u, r_s2_obs_v, r_s2_dir_x, r_s2_dir_y;

    logic signed [31:0] m [9];
    logic signed [31:0] pt [3];
    logic signed [31:0] pr [9];
    logic signed [31:0] cam [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_en) begin
            r_s1_v    <= i_valid;
            r_s1_item <= i_item;
            r_s1_xx   <= mulq(i_item.a, i_item.a, 30);
            r_s1_yy   <= mulq(i_item.b, i_item.b, 30);
            r_s1_zz   <= mulq(i_item.c, i_item.c, 30);
            r_s1_xy   <= mulq(i_item.a, i_item.b, 30);
            r_s1_xz   <= mulq(i_item.a, i_item.c, 30);
            r_s1_yz   <= mulq(i_item.b, i_item.c, 30);
            r_s1_xw   <= mulq(i_item.a, i_item.d, 30);
            r_s1_yw   <= mulq(i_item.b, i_item.d, 30);
            r_s1_zw   <= mulq(i_item.c, i_item.d, 30);
        end
    end

    always_comb begin
        m[0] = sat32(ONE30_W - ((66'(r_s1_yy) + 66'(r_s1_zz)) <<< 1));
        m[1] = sat32((66'(r_s1_xy) - 66'(r_s1_zw)) <<< 1);
        m[2] = sat32((66'(r_s1_xz) + 66'(r_s1_yw)) <<< 1);
        m[3] = sat32((66'(r_s1_xy) + 66'(r_s1_zw)) <<< 1);
        m[4] = sat32(ONE30_W - ((66'(r_s1_xx) + 66'(r_s1_zz)) <<< 1));
        m[5] = sat32((66'(r_s1_yz) - 66'(r_s1_xw)) <<< 1);
        m[6] = sat32((66'(r_s1_xz) - 66'(r_s1_yw)) <<< 1);
        m[7] = sat32((66'(r_s1_yz) + 66'(r_s1_xw)) <<< 1);
        m[8] = sat32(ONE30_W - ((66'(r_s1_xx) + 66'(r_s1_yy)) <<< 1));
        pt[0] = r_s1_item.a;
        pt[1] = r_s1_item.b;
        pt[2] = r_s1_item.c;
        for (int k = 0; k < 9; k++) begin
            pr[k] = mulq(r_rot[k], pt[k % 3], 30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_rot[k] <= (k == 0 || k == 4 || k == 8) ? ONE30_Q : 32'sd0;
            end
            for (int k = 0; k < 3; k++) begin
                r_trans[k] <= 32'sd0;
            end
        end else if (i_en) begin
            r_s2_v     <= r_s1_v && (r_s1_item.opcode == OPC_POINT);
            r_s2_prod  <= pr;
            r_s2_t     <= r_trans;
            r_s2_obs_u <= r_s1_item.d;
            r_s2_obs_v <= r_s1_item.e;
            r_s2_dir_x <= r_s1_item.f;
            r_s2_dir_y <= r_s1_item.g;
            if (r_s1_v && (r_s1_item.opcode == OPC_POSE)) begin
                r_rot      <= m;
                r_trans[0] <= r_s1_item.e;
                r_trans[1] <= r_s1_item.f;
                r_trans[2] <= r_s1_item.g;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cam[i] = sat32(66'(r_s2_prod[3 * i]) + 66'(r_s2_prod[3 * i + 1])
                           + 66'(r_s2_prod[3 * i + 2]) + 66'(r_s2_t[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid      <= r_s2_v;
            o_item.cam_x <= cam[0];
            o_item.cam_y <= cam[1];
            o_item.cam_z <= cam[2];
            o_item.obs_u <= r_s2_obs_u;
            o_item.obs_v <= r_s2_obs_v;
            o_item.dir_x <= r_s2_dir_x;
            o_item.dir_y <= r_s2_dir_y;
        end
    end

endmodule
`default_nettype wire

// ----- src/dwrr_div.sv -----
// Pipelined restoring divider forming x/z and y/z in Q4.28, one quotient bit per stage.
`default_nettype none
module dwrr_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  dwrr_pkg::t_cam_item  i_item,
    output logic                 o_valid,
    output dwrr_pkg::t_norm_item o_item
);
    import dwrr_pkg::*;

    localparam int NS = DIV_STEPS;

    logic        r_v    [NS + 1];
    t_side       r_side [NS + 1];
    logic [30:0] r_den  [NS + 1];
    logic [30:0] r_rem  [2][NS + 1];
    logic [30:0] r_quo  [2][NS + 1];
    logic [2:0]  r_low  [2][NS + 1];
    logic        r_neg  [2][NS + 1];
    logic        r_ovf  [2][NS + 1];

    logic signed [31:0] num [2];
    logic [31:0]        mag [2];
    logic               ovf [2];
    t_side              side_in;
    logic signed [31:0] res [2];

    always_comb begin
        num[0] = i_item.cam_x;
        num[1] = i_item.cam_y;
        for (int l = 0; l < 2; l++) begin
            mag[l] = num[l][31] ? (~num[l] + 32'd1) : num[l];
            ovf[l] = {2'b00, mag[l]} >= {i_item.cam_z[30:0], 3'b000};
        end
        side_in.obs_u  = i_item.obs_u;
        side_in.obs_v  = i_item.obs_v;
        side_in.dir_x  = i_item.dir_x;
        side_in.dir_y  = i_item.dir_y;
        side_in.behind = i_item.cam_z <= 32'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0]    <= i_valid;
            r_side[0] <= side_in;
            r_den[0]  <= i_item.cam_z[30:0];
            for (int l = 0; l < 2; l++) begin
                r_rem[l][0] <= 31'(mag[l][31:3]);
                r_quo[l][0] <= '0;
                r_low[l][0] <= mag[l][2:0];
                r_neg[l][0] <= num[l][31];
                r_ovf[l][0] <= ovf[l];
            end
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        localparam int BIT = (k < 3) ? (2 - k) : 0;
        logic [31:0] t [2];
        logic        q [2];

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                t[l] = {r_rem[l][k], (k < 3) ? r_low[l][k][BIT] : 1'b0};
                q[l] = t[l] >= {1'b0, r_den[k]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k + 1] <= 1'b0;
            end else if (i_en) begin
                r_v[k + 1]    <= r_v[k];
                r_side[k + 1] <= r_side[k];
                r_den[k + 1]  <= r_den[k];
                for (int l = 0; l < 2; l++) begin
                    r_rem[l][k + 1] <= q[l] ? 31'(t[l] - {1'b0, r_den[k]}) : t[l][30:0];
                    r_quo[l][k + 1] <= {r_quo[l][k][29:0], q[l]};
                    r_low[l][k + 1] <= r_low[l][k];
                    r_neg[l][k + 1] <= r_neg[l][k];
                    r_ovf[l][k + 1] <= r_ovf[l][k];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_ovf[l][NS]) begin
                res[l] = r_neg[l][NS] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else if (r_neg[l][NS]) begin
                res[l] = -$signed({1'b0, r_quo[l][NS]});
            end else begin
                res[l] = $signed({1'b0, r_quo[l][NS]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid     <= r_v[NS];
            o_item.xn   <= res[0];
            o_item.yn   <= res[1];
            o_item.side <= r_side[NS];
        end
    end

endmodule
`default_nettype wire

// ----- src/dwrr_distort.sv -----
// Radial and tangential distortion and intrinsics, nine stages from x/z, y/z to pixels.
`default_nettype none
module dwrr_distort (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  dwrr_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    input  dwrr_pkg::t_norm_item i_item,
    output logic                 o_valid,
    output dwrr_pkg::t_proj_item o_item
);
    import dwrr_pkg::*;

    logic  r_v [1:8];
    t_side r_side [1:8];

    logic signed [31:0] r_e1_xn, r_e1_yn, r_e1_x2, r_e1_y2, r_e1_xy;
    logic signed [31:0] r_e2_xn, r_e2_yn, r_e2_xy, r_e2_r2, r_e2_tx, r_e2_ty;
    logic signed [31:0] r_e3_xn, r_e3_yn, r_e3_r4, r_e3_k1r2;
    logic signed [31:0] r_e3_p1xy, r_e3_p2xy, r_e3_p2tx, r_e3_p1ty;
    logic signed [31:0] r_e4_xn, r_e4_yn, r_e4_k1r2, r_e4_k2r4;
    logic signed [31:0] r_e4_p1xy, r_e4_p2xy, r_e4_p2tx, r_e4_p1ty;
    logic signed [31:0] r_e5_xn, r_e5_yn, r_e5_dist;
    logic signed [31:0] r_e5_p1xy, r_e5_p2xy, r_e5_p2tx, r_e5_p1ty;
    logic signed [31:0] r_e6_xnd, r_e6_ynd;
    logic signed [31:0] r_e6_p1xy, r_e6_p2xy, r_e6_p2tx, r_e6_p1ty;
    logic signed [31:0] r_e7_xd, r_e7_yd;
    logic signed [31:0] r_e8_fxd, r_e8_fyd;

    logic signed [31:0] r2;

    assign r2 = sat32(66'(r_e1_x2) + 66'(r_e1_y2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 8; s++) begin
                r_v[s] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v[1] <= i_valid;
            for (int s = 2; s <= 8; s++) begin
                r_v[s] <= r_v[s - 1];
            end
            o_valid <= r_v[8];
            r_side[1] <= i_item.side;
            for (int s = 2; s <= 8; s++) begin
                r_side[s] <= r_side[s - 1];
            end

            r_e1_xn <= i_item.xn;
            r_e1_yn <= i_item.yn;
            r_e1_x2 <= mulq(i_item.xn, i_item.xn, 28);
            r_e1_y2 <= mulq(i_item.yn, i_item.yn, 28);
            r_e1_xy <= mulq(i_item.xn, i_item.yn, 28);

            r_e2_xn <= r_e1_xn;
            r_e2_yn <= r_e1_yn;
            r_e2_xy <= r_e1_xy;
            r_e2_r2 <= r2;
            r_e2_tx <= sat32(66'(r2) + (66'(r_e1_x2) <<< 1));
            r_e2_ty <= sat32(66'(r2) + (66'(r_e1_y2) <<< 1));

            r_e3_xn   <= r_e2_xn;
            r_e3_yn   <= r_e2_yn;
            r_e3_r4   <= mulq(r_e2_r2, r_e2_r2, 28);
            r_e3_k1r2 <= mulq(i_cfg.k1, r_e2_r2, 28);
            r_e3_p1xy <= mulq(i_cfg.p1, r_e2_xy, 28);
            r_e3_p2xy <= mulq(i_cfg.p2, r_e2_xy, 28);
            r_e3_p2tx <= mulq(i_cfg.p2, r_e2_tx, 28);
            r_e3_p1ty <= mulq(i_cfg.p1, r_e2_ty, 28);

            r_e4_xn   <= r_e3_xn;
            r_e4_yn   <= r_e3_yn;
            r_e4_k1r2 <= r_e3_k1r2;
            r_e4_k2r4 <= mulq(i_cfg.k2, r_e3_r4, 28);
            r_e4_p1xy <= r_e3_p1xy;
            r_e4_p2xy <= r_e3_p2xy;
            r_e4_p2tx <= r_e3_p2tx;
            r_e4_p1ty <= r_e3_p1ty;

            r_e5_xn   <= r_e4_xn;
            r_e5_yn   <= r_e4_yn;
            r_e5_dist <= sat32(ONE28_W + 66'(r_e4_k1r2) + 66'(r_e4_k2r4));
            r_e5_p1xy <= r_e4_p1xy;
            r_e5_p2xy <= r_e4_p2xy;
            r_e5_p2tx <= r_e4_p2tx;
            r_e5_p1ty <= r_e4_p1ty;

            r_e6_xnd  <= mulq(r_e5_xn, r_e5_dist, 28);
            r_e6_ynd  <= mulq(r_e5_yn, r_e5_dist, 28);
            r_e6_p1xy <= r_e5_p1xy;
            r_e6_p2xy <= r_e5_p2xy;
            r_e6_p2tx <= r_e5_p2tx;
            r_e6_p1ty <= r_e5_p1ty;

            r_e7_xd <= sat32(66'(r_e6_xnd) + (66'(r_e6_p1xy) <<< 1) + 66'(r_e6_p2tx));
            r_e7_yd <= sat32(66'(r_e6_ynd) + (66'(r_e6_p2xy) <<< 1) + 66'(r_e6_p1ty));

            r_e8_fxd <= mulq($signed({1'b0, i_cfg.focal_x}), r_e7_xd, 28);
            r_e8_fyd <= mulq($signed({1'b0, i_cfg.focal_y}), r_e7_yd, 28);

            o_item.ud   <= sat32(66'(r_e8_fxd) + 66'($signed({1'b0, i_cfg.center_x})));
            o_item.vd   <= sat32(66'(r_e8_fyd) + 66'($signed({1'b0, i_cfg.center_y})));
            o_item.side <= r_side[8];
        end
    end

endmodule
`default_nettype wire

// ----- src/dwrr_weight.sv -----
// Pixel residual, direction weighting through I - n n^T, saturation and output register.
`default_nettype none
module dwrr_weight #(
    parameter int WORD_WIDTH = dwrr_pkg::WORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  dwrr_pkg::t_proj_item i_item,
    output logic                 o_valid,
    output logic signed [31:0]   o_residual_u,
    output logic signed [31:0]   o_residual_v,
    output logic                 o_behind_camera,
    output logic                 o_saturated
);
    import dwrr_pkg::*;

    localparam int RES = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
    localparam logic signed [35:0] RES_HI = (36'sd1 <<< (RES - 1)) - 36'sd1;
    localparam logic signed [35:0] RES_LO = -RES_HI - 36'sd1;

    function automatic logic [32:0] clamp_res(input logic signed [35:0] v);
        logic [32:0] res;
        if (v > RES_HI) begin
            res = {1'b1, RES_HI[31:0]};
        end else if (v < RES_LO) begin
            res = {1'b1, RES_LO[31:0]};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    logic r_v [1:4];
    logic r_beh [1:4];
    logic r_dz [1:4];
    logic r_hit [1:4];
    logic signed [31:0] r_r0 [1:4];
    logic signed [31:0] r_r1 [1:4];

    logic signed [31:0] r_w1_nxx, r_w1_nxy, r_w1_nyy;
    logic signed [31:0] r_w2_v00, r_w2_v01, r_w2_v11;
    logic signed [31:0] r_w3_w00, r_w3_w01, r_w3_w11;
    logic signed [35:0] r_w4_pa0, r_w4_pa1, r_w4_pb0, r_w4_pb1;

    logic [32:0]        c0, c1, ca, cb;
    logic signed [63:0] pa0, pa1, pb0, pb1;

    always_comb begin
        c0  = clamp_res(36'(i_item.ud) - 36'(i_item.side.obs_u));
        c1  = clamp_res(36'(i_item.vd) - 36'(i_item.side.obs_v));
        pa0 = r_w3_w00 * r_r0[3];
        pa1 = r_w3_w01 * r_r1[3];
        pb0 = r_w3_w01 * r_r0[3];
        pb1 = r_w3_w11 * r_r1[3];
        ca  = clamp_res(r_w4_pa0 + r_w4_pa1);
        cb  = clamp_res(r_w4_pb0 + r_w4_pb1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 4; s++) begin
                r_v[s] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v[1] <= i_valid;
            for (int s = 2; s <= 4; s++) begin
                r_v[s]   <= r_v[s - 1];
                r_beh[s] <= r_beh[s - 1];
                r_dz[s]  <= r_dz[s - 1];
                r_hit[s] <= r_hit[s - 1];
                r_r0[s]  <= r_r0[s - 1];
                r_r1[s]  <= r_r1[s - 1];
            end
            o_valid <= r_v[4];

            r_beh[1] <= i_item.side.behind;
            r_dz[1]  <= (i_item.side.dir_x == 32'sd0) && (i_item.side.dir_y == 32'sd0);
            r_hit[1] <= c0[32] | c1[32];
            r_r0[1]  <= c0[31:0];
            r_r1[1]  <= c1[31:0];
            r_w1_nxx <= mulq(i_item.side.dir_x, i_item.side.dir_x, 30);
            r_w1_nxy <= mulq(i_item.side.dir_x, i_item.side.dir_y, 30);
            r_w1_nyy <= mulq(i_item.side.dir_y, i_item.side.dir_y, 30);

            r_w2_v00 <= sat32(ONE30_W - 66'(r_w1_nxx));
            r_w2_v01 <= sat32(-66'(r_w1_nxy));
            r_w2_v11 <= sat32(ONE30_W - 66'(r_w1_nyy));

            r_w3_w00 <= mulq(r_w2_v00, r_w2_v00, 30);
            r_w3_w01 <= mulq(r_w2_v01, r_w2_v01, 30);
            r_w3_w11 <= mulq(r_w2_v11, r_w2_v11, 30);

            r_w4_pa0 <= 36'(pa0 >>> 30);
            r_w4_pa1 <= 36'(pa1 >>> 30);
            r_w4_pb0 <= 36'(pb0 >>> 30);
            r_w4_pb1 <= 36'(pb1 >>> 30);

            if (r_beh[4]) begin
                o_residual_u    <= 32'sd0;
                o_residual_v    <= 32'sd0;
                o_behind_camera <= 1'b1;
                o_saturated     <= 1'b0;
            end else if (r_dz[4]) begin
                o_residual_u    <= r_r0[4];
                o_residual_v    <= r_r1[4];
                o_behind_camera <= 1'b0;
                o_saturated     <= r_hit[4];
            end else begin
                o_residual_u    <= ca[31:0];
                o_residual_v    <= cb[31:0];
                o_behind_camera <= 1'b0;
                o_saturated     <= r_hit[4] | ca[32] | cb[32];
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/direction_weighted_reprojection_residual.sv -----
// Top level of the direction-weighted reprojection residual pipeline.
// Usage:
// The input channel (i_valid, o_stall) takes one beat per cycle while o_stall is low.
// Opcode pose loads a quaternion and translation into the rotation state and yields
// no result; opcode point yields exactly one result beat on the output channel
// (o_valid, i_stall). Throughput is one beat per cycle when the output is not stalled.
// The restoring divider that forms x/z and y/z, with its 31 quotient-bit stages, is
// the longest part of the pipeline.
// The whole pipeline advances together whenever the output register is empty or taken.
// When the receiver stalls, the pipeline holds and the input register still takes one
// more beat before o_stall rises; nothing is lost or repeated.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) are registered and
// belong to idle periods. Synchronous active-low reset restores the default intrinsics,
// zero distortion, identity rotation and zero translation, and empties the pipeline.
// Behind-camera points give zero residuals with o_behind_camera set.
`default_nettype none
`include "direction_weighted_reprojection_residual_defines.svh"
module direction_weighted_reprojection_residual #(
    parameter int WORD_WIDTH = dwrr_pkg::WORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic signed [31:0] i_value_a,
    input  logic signed [31:0] i_value_b,
    input  logic signed [31:0] i_value_c,
    input  logic signed [31:0] i_value_d,
    input  logic signed [31:0] i_value_e,
    input  logic signed [31:0] i_value_f,
    input  logic signed [31:0] i_value_g,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_residual_u,
    output logic signed [31:0] o_residual_v,
    output logic               o_behind_camera,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import dwrr_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_v;
    t_in_item   r_in_item;
    logic       adv;
    logic       in_load;
    logic       cam_v, norm_v, proj_v;
    t_cam_item  cam_item;
    t_norm_item norm_item;
    t_proj_item proj_item;

    assign adv     = !o_valid || !i_stall;
    assign in_load = !r_in_v || adv;
    assign o_stall = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x  <= 32'd65536000;
            r_cfg.focal_y  <= 32'd65536000;
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.k1       <= '0;
            r_cfg.k2       <= '0;
            r_cfg.p1       <= '0;
            r_cfg.p2       <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_FOCAL_X:  r_cfg.focal_x  <= i_cfg_data;
                REG_FOCAL_Y:  r_cfg.focal_y  <= i_cfg_data;
                REG_CENTER_X: r_cfg.center_x <= i_cfg_data;
                REG_CENTER_Y: r_cfg.center_y <= i_cfg_data;
                REG_RAD_K1:   r_cfg.k1       <= $signed(i_cfg_data);
                REG_RAD_K2:   r_cfg.k2       <= $signed(i_cfg_data);
                REG_TAN_P1:   r_cfg.p1       <= $signed(i_cfg_data);
                REG_TAN_P2:   r_cfg.p2       <= $signed(i_cfg_data);
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_load) begin
            r_in_v           <= i_valid;
            r_in_item.opcode <= i_opcode;
            r_in_item.a      <= i_value_a;
            r_in_item.b      <= i_value_b;
            r_in_item.c      <= i_value_c;
            r_in_item.d      <= i_value_d;
            r_in_item.e      <= i_value_e;
            r_in_item.f      <= i_value_f;
            r_in_item.g      <= i_value_g;
        end
    end

    dwrr_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_in_v),
        .i_item  (r_in_item),
        .o_valid (cam_v),
        .o_item  (cam_item)
    );

    dwrr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (cam_v),
        .i_item  (cam_item),
        .o_valid (norm_v),
        .o_item  (norm_item)
    );

    dwrr_distort u_distort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_cfg   (r_cfg),
        .i_valid (norm_v),
        .i_item  (norm_item),
        .o_valid (proj_v),
        .o_item  (proj_item)
    );

    dwrr_weight #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_weight (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (adv),
        .i_valid         (proj_v),
        .i_item          (proj_item),
        .o_valid         (o_valid),
        .o_residual_u    (o_residual_u),
        .o_residual_v    (o_residual_v),
        .o_behind_camera (o_behind_camera),
        .o_saturated     (o_saturated)
    );

    `DWRR_ASSERT_NOW(a_behind_zero, i_clk, i_rst_n, o_valid && o_behind_camera,
        o_residual_u == 32'sd0 && o_residual_v == 32'sd0 && !o_saturated,
        "Behind-camera beat carries nonzero residual or saturation.")

    `DWRR_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall,
        o_valid && i_stall && r_in_v,
        "Input stalled although the output side is free.")

    `DWRR_ASSERT_NEXT(a_cfg_fx, i_clk, i_rst_n,
        i_rst_n && i_cfg_we && i_cfg_idx == REG_FOCAL_X,
        r_cfg.focal_x == $past(i_cfg_data),
        "Focal length write did not land.")

    `DWRR_ASSERT_NEXT(a_hold_output, i_clk, i_rst_n,
        i_rst_n && o_valid && i_stall,
        o_valid && $stable(o_residual_u) && $stable(o_residual_v),
        "Stalled result beat changed.")

endmodule
`default_nettype wire
